FILE: rtl/scld_pkg.sv
`timescale 1ns / 1ps

package scld_pkg;

    localparam int MAX_COMMANDS_DEF = 16;
    localparam int NAME_LEN_DEF     = 16;
    localparam int BUFFER_LEN_DEF   = 64;

    // widest command index over the whole parameter range (up to 64 entries)
    localparam int CMD_IDX_W = 6;
    localparam int LEN_W     = 7;
    localparam logic [LEN_W-1:0] LEN_SAT = 7'd127;

    localparam logic [7:0] PRINT_LO = 8'h20;
    localparam logic [7:0] PRINT_HI = 8'h7E;

    localparam logic       OP_STREAM = 1'b0;
    localparam logic       OP_LOAD   = 1'b1;

    localparam logic [2:0] CFG_COMMAND_COUNT = 3'd0;
    localparam logic [2:0] CFG_TERMINATOR    = 3'd1;
    localparam logic [2:0] CFG_DELIMITER     = 3'd2;
    localparam logic [2:0] CFG_UNKNOWN_EN    = 3'd3;
    localparam logic [2:0] CFG_EMPTY_EN      = 3'd4;

    localparam logic [4:0] COMMAND_COUNT_RST = 5'd0;
    localparam logic [7:0] TERMINATOR_RST    = 8'd13;
    localparam logic [7:0] DELIMITER_RST     = 8'd32;

    typedef enum logic [1:0]
    {
        PH_SKIP = 2'd0,
        PH_WORD = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    typedef enum logic [1:0]
    {
        EV_MATCH   = 2'd0,
        EV_UNKNOWN = 2'd1,
        EV_EMPTY   = 2'd2
    } event_kind_t;

    typedef enum logic
    {
        TOK_CMP = 1'b0,
        TOK_EQ  = 1'b1
    } tok_kind_t;

    typedef struct packed
    {
        logic                 valid;
        tok_kind_t            kind;
        logic [7:0]           ch;
        logic [LEN_W-1:0]     pos;
        logic                 found;
        logic [CMD_IDX_W-1:0] found_idx;
    } tok_t;

    typedef struct packed
    {
        logic       en;
        logic [3:0] entry;
        logic [3:0] pos;
        logic [7:0] data;
    } load_t;

endpackage

FILE: rtl/scld_cell.sv
`timescale 1ns / 1ps

module scld_cell
#(
    parameter int INDEX    = 0,
    parameter int NAME_LEN = scld_pkg::NAME_LEN_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  scld_pkg::load_t  load,
    input  logic [4:0]       command_count,
    input  scld_pkg::tok_t   tok_in,
    output scld_pkg::tok_t   tok_out
);

    localparam int AW = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;

    logic [7:0]            name_mem [NAME_LEN];
    logic [7:0]            rd_reg;
    logic                  flag_reg;
    logic                  flag_next;
    scld_pkg::tok_t        tok_reg;

    logic [6:0]            wpos_ext;
    logic                  wr_hit;
    logic [AW-1:0]         waddr;
    logic [AW-1:0]         raddr;
    logic                  in_range;
    logic                  active;
    logic                  eq;

    assign wpos_ext = {3'b000, load.pos};
    assign waddr    = wpos_ext[AW-1:0];
    assign raddr    = tok_in.pos[AW-1:0];
    assign wr_hit   = load.en && ({2'b00, load.entry} == 6'(INDEX))
                      && (wpos_ext < 7'(NAME_LEN));

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            name_mem[waddr] <= load.data;
        end
        if (tok_in.valid)
        begin
            rd_reg <= name_mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg  <= '0;
            flag_reg <= 1'b1;
        end
        else
        begin
            tok_reg <= tok_in;
            if (tok_reg.valid)
            begin
                flag_reg <= flag_next;
            end
        end
    end

    assign in_range = tok_reg.pos < 7'(NAME_LEN);
    assign active   = 6'(INDEX) < {1'b0, command_count};

    always_comb
    begin
        tok_out   = tok_reg;
        flag_next = flag_reg;
        eq        = 1'b0;
        unique case (tok_reg.kind)
            scld_pkg::TOK_CMP:
            begin
                flag_next = flag_reg && in_range && (rd_reg == tok_reg.ch);
            end
            scld_pkg::TOK_EQ:
            begin
                eq = flag_reg && active
                     && (in_range ? (rd_reg == 8'd0) : (tok_reg.pos == 7'(NAME_LEN)));
                if (!tok_reg.found && eq)
                begin
                    tok_out.found     = 1'b1;
                    tok_out.found_idx = scld_pkg::CMD_IDX_W'(INDEX);
                end
                // line ends here: flags return to all ones
                flag_next = 1'b1;
            end
            default:
            begin
                flag_next = flag_reg;
            end
        endcase
    end

endmodule

FILE: rtl/scld_ctrl.sv
`timescale 1ns / 1ps

module scld_ctrl
#(
    parameter int BUFFER_LEN = scld_pkg::BUFFER_LEN_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic                 operation,
    input  logic [7:0]           byte_value,
    input  logic [3:0]           entry_index,
    input  logic [3:0]           char_position,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [7:0]           cfg_data,

    output logic                 event_valid,
    input  logic                 event_stall,
    output logic [1:0]           event_kind,
    output logic [3:0]           command_index,
    output logic [6:0]           word_length,

    output scld_pkg::load_t      load,
    output logic [4:0]           command_count,
    output scld_pkg::tok_t       tok_launch,
    input  scld_pkg::tok_t       tok_end
);

    localparam int CW = $clog2(BUFFER_LEN + 1);

    logic [4:0]                  command_count_reg;
    logic [7:0]                  terminator_reg;
    logic [7:0]                  delimiter_reg;
    logic                        unknown_en_reg;
    logic                        empty_en_reg;

    scld_pkg::phase_t            phase_reg, phase_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [6:0]                  len_reg, len_next;
    logic                        busy_reg, busy_next;

    logic                        out_valid_reg, out_valid_next;
    scld_pkg::event_kind_t       kind_reg, kind_next;
    logic [3:0]                  idx_reg, idx_next;
    logic [6:0]                  wlen_reg, wlen_next;

    logic                        is_stream;
    logic                        is_term;
    logic                        printable;
    logic                        acc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_count_reg <= scld_pkg::COMMAND_COUNT_RST;
            terminator_reg    <= scld_pkg::TERMINATOR_RST;
            delimiter_reg     <= scld_pkg::DELIMITER_RST;
            unknown_en_reg    <= 1'b0;
            empty_en_reg      <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                scld_pkg::CFG_COMMAND_COUNT: command_count_reg <= cfg_data[4:0];
                scld_pkg::CFG_TERMINATOR:    terminator_reg    <= cfg_data;
                scld_pkg::CFG_DELIMITER:     delimiter_reg     <= cfg_data;
                scld_pkg::CFG_UNKNOWN_EN:    unknown_en_reg    <= cfg_data[0];
                scld_pkg::CFG_EMPTY_EN:      empty_en_reg      <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign is_stream  = (operation == scld_pkg::OP_STREAM);
    assign is_term    = is_stream && (byte_value == terminator_reg);
    assign printable  = (byte_value >= scld_pkg::PRINT_LO) && (byte_value <= scld_pkg::PRINT_HI);
    assign item_stall = busy_reg || (is_term && out_valid_reg && event_stall);
    assign acc        = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= scld_pkg::PH_SKIP;
            count_reg     <= '0;
            len_reg       <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            len_reg       <= len_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        idx_reg  <= idx_next;
        wlen_reg <= wlen_next;
    end

    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        len_next       = len_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg && event_stall;
        kind_next      = kind_reg;
        idx_next       = idx_reg;
        wlen_next      = wlen_reg;

        tok_launch           = '0;
        tok_launch.ch        = byte_value;

        load.en    = acc && (operation == scld_pkg::OP_LOAD);
        load.entry = entry_index;
        load.pos   = char_position;
        load.data  = byte_value;

        if (acc && is_stream)
        begin
            if (is_term)
            begin
                if (phase_reg == scld_pkg::PH_SKIP)
                begin
                    if (empty_en_reg)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = scld_pkg::EV_EMPTY;
                        idx_next       = 4'd0;
                        wlen_next      = 7'd0;
                    end
                end
                else
                begin
                    tok_launch.valid = 1'b1;
                    tok_launch.kind  = scld_pkg::TOK_EQ;
                    tok_launch.pos   = len_reg;
                    busy_next        = 1'b1;
                end
                phase_next = scld_pkg::PH_SKIP;
                count_next = '0;
                len_next   = '0;
            end
            else if (printable && (count_reg < CW'(BUFFER_LEN)))
            begin
                count_next = count_reg + CW'(1);
                unique case (phase_reg)
                    scld_pkg::PH_SKIP:
                    begin
                        if (byte_value != delimiter_reg)
                        begin
                            phase_next       = scld_pkg::PH_WORD;
                            tok_launch.valid = 1'b1;
                            tok_launch.kind  = scld_pkg::TOK_CMP;
                            tok_launch.pos   = 7'd0;
                            len_next         = 7'd1;
                            busy_next        = 1'b1;
                        end
                    end
                    scld_pkg::PH_WORD:
                    begin
                        if (byte_value == delimiter_reg)
                        begin
                            phase_next = scld_pkg::PH_DONE;
                        end
                        else
                        begin
                            tok_launch.valid = 1'b1;
                            tok_launch.kind  = scld_pkg::TOK_CMP;
                            tok_launch.pos   = len_reg;
                            busy_next        = 1'b1;
                            if (len_reg < scld_pkg::LEN_SAT)
                            begin
                                len_next = len_reg + 7'd1;
                            end
                        end
                    end
                    scld_pkg::PH_DONE:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        if (tok_end.valid)
        begin
            busy_next = 1'b0;
            if (tok_end.kind == scld_pkg::TOK_EQ)
            begin
                if (tok_end.found)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = scld_pkg::EV_MATCH;
                    idx_next       = tok_end.found_idx[3:0];
                    wlen_next      = tok_end.pos;
                end
                else if (unknown_en_reg)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = scld_pkg::EV_UNKNOWN;
                    idx_next       = 4'd0;
                    wlen_next      = tok_end.pos;
                end
            end
        end
    end

    assign command_count = command_count_reg;
    assign event_valid   = out_valid_reg;
    assign event_kind    = kind_reg;
    assign command_index = idx_reg;
    assign word_length   = wlen_reg;

    a_end_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tok_end.valid |-> busy_reg)
        else $error("chain transaction emerged while idle");

    a_skip_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == scld_pkg::PH_SKIP) |-> (len_reg == 7'd0))
        else $error("word length set outside a word");

    a_word_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != scld_pkg::PH_SKIP) |-> (len_reg != 7'd0))
        else $error("word phase with empty word");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(BUFFER_LEN))
        else $error("line count beyond buffer");

    a_match_reported: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_end.valid && (tok_end.kind == scld_pkg::TOK_EQ) && tok_end.found)
        |=> (out_valid_reg && (kind_reg == scld_pkg::EV_MATCH)))
        else $error("match lost at end of chain");

endmodule

FILE: rtl/serial_command_line_dispatcher_unit.sv
`timescale 1ns / 1ps

// channel   handshake              payload
// item      item_valid/item_stall  operation, byte_value, entry_index, char_position
// cfg       cfg_valid/cfg_ready    cfg_index, cfg_data
// event     event_valid/event_stall event_kind, command_index, word_length
//
// A stream byte that is compared, or a terminator ending a line that holds a word,
// launches one transaction that walks the row of entry cells, one cell per cycle;
// no new item is taken until it leaves the last cell.
// Load items and bytes that launch no pass leave the unit free for the next item.
// Reset clears the line state and the configuration registers; names are undefined until loaded.
// A terminator is held off while a previous event sits stalled at the output.

module serial_command_line_dispatcher_unit
#(
    parameter int MAX_COMMANDS = scld_pkg::MAX_COMMANDS_DEF,
    parameter int NAME_LEN     = scld_pkg::NAME_LEN_DEF,
    parameter int BUFFER_LEN   = scld_pkg::BUFFER_LEN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    output logic        item_stall,
    input  logic        operation,
    input  logic [7:0]  byte_value,
    input  logic [3:0]  entry_index,
    input  logic [3:0]  char_position,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,

    output logic        event_valid,
    input  logic        event_stall,
    output logic [1:0]  event_kind,
    output logic [3:0]  command_index,
    output logic [6:0]  word_length
);

    scld_pkg::tok_t  tok [MAX_COMMANDS+1];
    scld_pkg::load_t load;
    logic [4:0]      command_count;

    scld_ctrl
    #(
        .BUFFER_LEN (BUFFER_LEN)
    )
    u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .operation     (operation),
        .byte_value    (byte_value),
        .entry_index   (entry_index),
        .char_position (char_position),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .event_valid   (event_valid),
        .event_stall   (event_stall),
        .event_kind    (event_kind),
        .command_index (command_index),
        .word_length   (word_length),
        .load          (load),
        .command_count (command_count),
        .tok_launch    (tok[0]),
        .tok_end       (tok[MAX_COMMANDS])
    );

    for (genvar i = 0; i < MAX_COMMANDS; i++)
    begin : g_cell
        scld_cell
        #(
            .INDEX    (i),
            .NAME_LEN (NAME_LEN)
        )
        u_cell
        (
            .clk           (clk),
            .rst_n         (rst_n),
            .load          (load),
            .command_count (command_count),
            .tok_in        (tok[i]),
            .tok_out       (tok[i+1])
        );
    end

endmodule
